/* rtl/core/lcst_pkg.sv */
// lcst_pkg: shared constants and types for the least-connections server table
// used by lcst_cell and least_connections_server_table; no dependencies
package lcst_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int IDX_W     = $clog2(NUM_SLOTS);

    localparam int REQ_W     = 2;
    localparam int SLOT_W    = 6;
    localparam int LOAD_W    = 16;
    localparam int IP_W      = 32;
    localparam int PORT_W    = 16;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    localparam logic [REQ_W-1:0] REQ_REPORT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // write command broadcast to every cell
    typedef struct packed {
        logic              wr;
        logic              remove;
        logic [IDX_W-1:0]  idx;
        logic [LOAD_W-1:0] load;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
    } cmd_t;

    // best-so-far candidate handed from cell to cell during a query
    typedef struct packed {
        logic              tok;
        logic              found;
        logic [LOAD_W-1:0] load;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
    } cand_t;

endpackage

/* rtl/core/lcst_cell.sv */
// lcst_cell: one table entry plus one stage of the least-load search chain
// depends on lcst_pkg
module lcst_cell
    import lcst_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  cmd_t             cmd,
    input  cand_t            cand_in,
    output cand_t            cand_out,
    output logic             valid
);

    logic              valid_reg;
    logic              valid_next;
    logic [LOAD_W-1:0] load_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [PORT_W-1:0] port_reg;
    logic              tok_reg;
    cand_t             cand_reg;
    cand_t             cand_next;
    logic              hit;
    logic              take;

    assign hit = cmd.wr && (cmd.idx == cell_idx);

    always_comb begin
        valid_next = valid_reg;
        if (hit) begin
            valid_next = !cmd.remove;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hit && !cmd.remove) begin
            load_reg <= cmd.load;
            if (!valid_reg) begin
                ip_reg   <= cmd.ip;
                port_reg <= cmd.port;
            end
        end
    end

    // strict less-than keeps the lower slot on a tie
    assign take = valid_reg && (!cand_in.found || (load_reg < cand_in.load));

    always_comb begin
        cand_next     = cand_in;
        cand_next.tok = 1'b0;
        if (take) begin
            cand_next.found = 1'b1;
            cand_next.load  = load_reg;
            cand_next.ip    = ip_reg;
            cand_next.port  = port_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= 1'b0;
        end else begin
            tok_reg <= cand_in.tok;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
    end

    always_comb begin
        cand_out     = cand_reg;
        cand_out.tok = tok_reg;
    end

    assign valid = valid_reg;

endmodule

/* rtl/core/least_connections_server_table.sv */
// least_connections_server_table: top level, request control and the chain of table cells
// depends on lcst_pkg and lcst_cell
//
//  port group  dir  carries
//  s_*         in   request item: tuser req_type, tdata slot/conn_count/peer_ip/peer_port
//  m_*         out  result item: tdata status/ip/port/load/newly_added/was_present
//
// report and remove: result registered in the cycle after the item is taken
// query: a token walks the cell chain one slot per cycle, result via a pending register
// one request at a time; a new item is taken once the output register is free
// reset clears every valid bit and the chain token
// a stalled m_tready holds the result and blocks further items
module least_connections_server_table
    import lcst_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] req_type
    input  logic [REQ_W-1:0]     s_tuser,
    // [5:0] slot, [21:6] conn_count, [53:22] peer_ip, [69:54] peer_port, [71:70] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] status, [32:1] server_ip, [48:33] server_port, [64:49] server_load,
    // [65] newly_added, [66] was_present, [71:67] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;
    logic [M_TDATA_W-1:0] pend_reg;
    logic [M_TDATA_W-1:0] pend_next;

    logic                 accept;
    logic                 out_free;
    logic [SLOT_W-1:0]    in_slot;
    logic [LOAD_W-1:0]    in_load;
    logic [IP_W-1:0]      in_ip;
    logic [PORT_W-1:0]    in_port;
    logic                 in_range;
    logic [IDX_W-1:0]     idx;
    logic                 slot_valid;
    logic [M_TDATA_W-1:0] simple_res;
    logic [M_TDATA_W-1:0] query_res;

    cmd_t                 cmd;
    cand_t                chain [NUM_SLOTS+1];
    logic [NUM_SLOTS-1:0] valid_vec;
    logic [NUM_SLOTS-1:0] tok_vec;

    function automatic logic [M_TDATA_W-1:0] pack_res(
        input logic              status,
        input logic [IP_W-1:0]   ip,
        input logic [PORT_W-1:0] port,
        input logic [LOAD_W-1:0] load,
        input logic              added,
        input logic              present
    );
        logic [M_TDATA_W-1:0] r;
        r        = '0;
        r[0]     = status;
        r[32:1]  = ip;
        r[48:33] = port;
        r[64:49] = load;
        r[65]    = added;
        r[66]    = present;
        return r;
    endfunction

    assign in_slot  = s_tdata[5:0];
    assign in_load  = s_tdata[21:6];
    assign in_ip    = s_tdata[53:22];
    assign in_port  = s_tdata[69:54];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign in_range   = 32'(in_slot) < NUM_SLOTS;
    assign idx        = IDX_W'(in_slot);
    assign slot_valid = valid_vec[idx];

    always_comb begin
        cmd        = '0;
        cmd.wr     = accept && in_range
                     && ((s_tuser == REQ_REPORT) || (s_tuser == REQ_REMOVE));
        cmd.remove = (s_tuser == REQ_REMOVE);
        cmd.idx    = idx;
        cmd.load   = in_load;
        cmd.ip     = in_ip;
        cmd.port   = in_port;
    end

    always_comb begin
        simple_res = '0;
        if (in_range && (s_tuser == REQ_REPORT)) begin
            simple_res = pack_res(1'b0, '0, '0, '0, !slot_valid, 1'b0);
        end else if (in_range && (s_tuser == REQ_REMOVE)) begin
            simple_res = pack_res(1'b0, '0, '0, '0, 1'b0, slot_valid);
        end
    end

    // seed the chain with an empty candidate when a query is taken
    always_comb begin
        chain[0]     = '0;
        chain[0].tok = accept && (s_tuser == REQ_QUERY);
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
            lcst_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (IDX_W'(gi)),
                .cmd      (cmd),
                .cand_in  (chain[gi]),
                .cand_out (chain[gi+1]),
                .valid    (valid_vec[gi])
            );
            assign tok_vec[gi] = chain[gi+1].tok;
        end
    endgenerate

    always_comb begin
        if (chain[NUM_SLOTS].found) begin
            query_res = pack_res(1'b0, chain[NUM_SLOTS].ip, chain[NUM_SLOTS].port,
                                 chain[NUM_SLOTS].load, 1'b0, 1'b0);
        end else begin
            query_res = pack_res(1'b1, '0, '0, '0, 1'b0, 1'b0);
        end
    end

    always_comb begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == REQ_QUERY) begin
                        state_next = ST_SCAN;
                    end else begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = simple_res;
                    end
                end
            end
            ST_SCAN: begin
                if (chain[NUM_SLOTS].tok) begin
                    pend_next  = query_res;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pend_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        pend_reg    <= pend_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // only one query token may be in the chain
    assert property (@(posedge aclk) disable iff (!aresetn) $onehot0(tok_vec))
        else $error("more than one search token in the cell chain");

    assert property (@(posedge aclk) disable iff (!aresetn)
        chain[NUM_SLOTS].tok |-> (state_reg == ST_SCAN))
        else $error("search token left the chain outside a scan");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (chain[NUM_SLOTS].tok && !chain[NUM_SLOTS].found) |-> (valid_vec == '0))
        else $error("scan found nothing while a slot is valid");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !cmd.wr)
        else $error("table written during a query");
`endif

endmodule
